### design/tdf_pkg.sv
`timescale 1ns / 1ps

package tdf_pkg;

	localparam int WIDTH     = 32;
	localparam int FACTOR_W  = 32;
	localparam int EXP_W     = 6;
	localparam int ITER_W    = $clog2(WIDTH);
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = ((FACTOR_W + EXP_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		SEL_DIV,
		SEL_REM,
		SEL_NONE
	} out_sel_t;

	typedef struct packed {
		logic     load;
		logic     div_start;
		logic     take_quot;
		logic     next_div;
		logic     out_load;
		out_sel_t out_sel;
		logic     out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic rem_zero;
		logic stop;
		logic rem_le1;
		logic rem_one;
		logic cnt_nz;
	} dp_sts_t;

endpackage

### design/tdf_divider.sv
`timescale 1ns / 1ps

module tdf_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tdf_pkg::WIDTH-1:0] dividend,
	input  logic [tdf_pkg::WIDTH-1:0] divisor,
	output logic [tdf_pkg::WIDTH-1:0] quotient,
	output logic [tdf_pkg::WIDTH-1:0] remainder,
	output logic                      done
);

	logic [tdf_pkg::WIDTH-1:0]  quo_q;
	logic [tdf_pkg::WIDTH-1:0]  rem_q;
	logic [tdf_pkg::WIDTH-1:0]  dsr_q;
	logic [tdf_pkg::ITER_W-1:0] iter_q;
	logic                       busy_q;
	logic                       done_q;
	logic [tdf_pkg::WIDTH:0]    shifted;
	logic [tdf_pkg::WIDTH:0]    diff;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[tdf_pkg::WIDTH-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == tdf_pkg::ITER_W'(tdf_pkg::WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[tdf_pkg::WIDTH-2:0], ~diff[tdf_pkg::WIDTH]};
			if (!diff[tdf_pkg::WIDTH]) begin
				rem_q <= diff[tdf_pkg::WIDTH-1:0];
			end else begin
				rem_q <= shifted[tdf_pkg::WIDTH-1:0];
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

### design/tdf_datapath.sv
`timescale 1ns / 1ps

module tdf_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tdf_pkg::dp_cmd_t               cmd,
	output tdf_pkg::dp_sts_t               sts,
	input  logic [tdf_pkg::WIDTH-1:0]      number,
	output logic [tdf_pkg::FACTOR_W-1:0]   factor,
	output logic [tdf_pkg::EXP_W-1:0]      exponent,
	output logic                           last
);

	logic [tdf_pkg::WIDTH-1:0]    rem_q;
	logic [tdf_pkg::WIDTH-1:0]    div_q;
	logic [tdf_pkg::EXP_W-1:0]    cnt_q;
	logic [tdf_pkg::FACTOR_W-1:0] factor_q;
	logic [tdf_pkg::EXP_W-1:0]    exponent_q;
	logic                         last_q;
	logic [tdf_pkg::WIDTH-1:0]    quo;
	logic [tdf_pkg::WIDTH-1:0]    rmd;
	logic                         done;

	tdf_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (rem_q),
		.divisor   (div_q),
		.quotient  (quo),
		.remainder (rmd),
		.done      (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			div_q <= tdf_pkg::WIDTH'(2);
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				rem_q <= number;
				div_q <= tdf_pkg::WIDTH'(2);
				cnt_q <= '0;
			end else if (cmd.take_quot) begin
				rem_q <= quo;
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.next_div) begin
				div_q <= div_q + 1'b1;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last_q <= cmd.out_last;
			case (cmd.out_sel)
				tdf_pkg::SEL_DIV: begin
					factor_q   <= tdf_pkg::FACTOR_W'(div_q);
					exponent_q <= cnt_q;
				end
				tdf_pkg::SEL_REM: begin
					factor_q   <= tdf_pkg::FACTOR_W'(rem_q);
					exponent_q <= tdf_pkg::EXP_W'(1);
				end
				default: begin
					factor_q   <= '0;
					exponent_q <= '0;
				end
			endcase
		end
	end

	assign sts.div_done = done;
	assign sts.rem_zero = (rmd == '0);
	assign sts.stop     = (div_q > quo);
	assign sts.rem_le1  = (rem_q <= tdf_pkg::WIDTH'(1));
	assign sts.rem_one  = (rem_q == tdf_pkg::WIDTH'(1));
	assign sts.cnt_nz   = (cnt_q != '0);

	assign factor   = factor_q;
	assign exponent = exponent_q;
	assign last     = last_q;

endmodule

### design/tdf_ctrl.sv
`timescale 1ns / 1ps

module tdf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output tdf_pkg::dp_cmd_t cmd,
	input  tdf_pkg::dp_sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic              first_q;
	logic              out_valid_q;
	tdf_pkg::out_sel_t sel_q;
	logic              last_q;
	logic              out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.out_sel   = sel_q;
		cmd.out_last  = last_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_START: begin
				cmd.div_start = 1'b1;
			end
			ST_WAIT: begin
				if (sts.div_done && !(first_q && sts.stop)) begin
					if (sts.rem_zero) begin
						cmd.take_quot = 1'b1;
					end else if (!sts.cnt_nz) begin
						cmd.next_div = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.next_div = !last_q;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
			sel_q       <= tdf_pkg::SEL_NONE;
			last_q      <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						first_q <= 1'b1;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sts.rem_le1) begin
						sel_q   <= tdf_pkg::SEL_NONE;
						last_q  <= 1'b1;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (sts.div_done) begin
						if (first_q && sts.stop) begin
							sel_q   <= tdf_pkg::SEL_REM;
							last_q  <= 1'b1;
							state_q <= ST_EMIT;
						end else if (sts.rem_zero) begin
							first_q <= 1'b0;
							state_q <= ST_START;
						end else if (sts.cnt_nz) begin
							sel_q   <= tdf_pkg::SEL_DIV;
							last_q  <= sts.rem_one;
							state_q <= ST_EMIT;
						end else begin
							first_q <= 1'b1;
							state_q <= ST_START;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						first_q     <= 1'b1;
						state_q     <= last_q ? ST_IDLE : ST_START;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### design/trial_division_factorizer.sv
`timescale 1ns / 1ps

// channel   dir  fields (lowest bit up)                       handshake
// s_axis    in   tdata: number[31:0]                          tvalid/tready
// m_axis    out  tdata: factor[31:0], exponent[37:32], pad    tvalid/tready, tlast = last
//
// one number per run; the next is taken once the last result sits in the output register
// each trial division runs in the shared bit-serial divider
// a run takes about one trial division per trial divisor up to sqrt(n), plus one per prime power
// arst_n clears the controller and the divider; no run survives a reset
// a stalled m_axis transfer holds the controller before it loads the next result

module trial_division_factorizer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [tdf_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // number
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [tdf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // factor, exponent, zero pad
	output logic                                 m_axis_tlast
);

	tdf_pkg::dp_cmd_t              cmd;
	tdf_pkg::dp_sts_t              sts;
	logic [tdf_pkg::FACTOR_W-1:0]  factor;
	logic [tdf_pkg::EXP_W-1:0]     exponent;

	tdf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	tdf_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.number   (s_axis_tdata[tdf_pkg::WIDTH-1:0]),
		.factor   (factor),
		.exponent (exponent),
		.last     (m_axis_tlast)
	);

	assign m_axis_tdata = tdf_pkg::OUT_TDATA_W'({exponent, factor});

endmodule

### design/tdf_checker.sv
`timescale 1ns / 1ps

module tdf_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [tdf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [tdf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tlast
);

	logic [tdf_pkg::FACTOR_W-1:0] chk_factor;
	logic [tdf_pkg::EXP_W-1:0]    chk_exp;

	assign chk_factor = m_axis_tdata[tdf_pkg::FACTOR_W-1:0];
	assign chk_exp    = m_axis_tdata[tdf_pkg::FACTOR_W+tdf_pkg::EXP_W-1:tdf_pkg::FACTOR_W];

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// waiting number holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("waiting number changed");

	// one number at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while a run is in progress");

	// factor zero only as the single result of a trivial input
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && chk_factor == '0 |-> m_axis_tlast && chk_exp == '0)
		else $error("zero factor with nonzero exponent or not last");

	// a real prime always has a nonzero exponent, and is at least two
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && chk_factor != '0 |->
			chk_exp != '0 && chk_factor != tdf_pkg::FACTOR_W'(1))
		else $error("malformed factor");

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

### bench/trial_division_factorizer_tb.sv
`timescale 1ns / 1ps

module trial_division_factorizer_tb;

	localparam int MAX_TERMS  = 9;
	localparam int RAND_ITEMS = 82;

	typedef struct packed {
		logic [tdf_pkg::FACTOR_W-1:0] factor;
		logic [tdf_pkg::EXP_W-1:0]    exponent;
		logic                         last;
	} prime_term_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [tdf_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [tdf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
	logic                               m_axis_tlast;

	logic [31:0]    numbers_to_send[$];
	prime_term_t    expected_terms[$];
	prime_term_t    run_terms[MAX_TERMS];
	prime_term_t    got_term;
	int             trial_work;
	int             total_numbers;
	int             numbers_taken = 0;
	int             terms_seen = 0;
	int             longest_run = 0;
	int             top_exponent = 0;
	int             error_count = 0;
	longint         cycle_count = 0;
	longint         cycle_limit = 64'd100000000;

	trial_division_factorizer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // number[31:0]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // factor[31:0], exponent[37:32], zero pad
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// prime terms of num into run_terms, ascending; trial_work counts divider passes
	function automatic int factorize(logic [31:0] num);
		logic [31:0] rest;
		logic [31:0] div;
		int          cnt;
		int          n;
		n = 0;
		trial_work = 1;
		rest = num;
		div = 2;
		if (rest <= 1) begin
			run_terms[0].factor = '0;
			run_terms[0].exponent = '0;
			run_terms[0].last = 1'b1;
			return 1;
		end
		while (div <= rest / div) begin
			cnt = 0;
			while (rest % div == 0) begin
				rest = rest / div;
				cnt++;
				trial_work++;
			end
			if (cnt > 0 && n < MAX_TERMS) begin
				run_terms[n].factor = div;
				run_terms[n].exponent = cnt[tdf_pkg::EXP_W-1:0];
				run_terms[n].last = 1'b0;
				n++;
			end
			div++;
			trial_work++;
		end
		if (rest > 1 && n < MAX_TERMS) begin
			run_terms[n].factor = rest;
			run_terms[n].exponent = tdf_pkg::EXP_W'(1);
			run_terms[n].last = 1'b0;
			n++;
		end
		run_terms[n-1].last = 1'b1;
		return n;
	endfunction

	// product of small factors with repeats, sometimes times a larger cofactor
	function automatic logic [31:0] smooth_number();
		longint unsigned v;
		longint unsigned p;
		int              k;
		v = 1;
		repeat ($urandom_range(1, 12)) begin
			p = $urandom_range(2, 100);
			k = $urandom_range(1, 5);
			repeat (k) begin
				if (v * p <= 64'hFFFF_FFFF)
					v = v * p;
			end
		end
		if ($urandom_range(0, 2) == 0) begin
			p = $urandom_range(101, 4000);
			if (v * p <= 64'hFFFF_FFFF)
				v = v * p;
		end
		return v[31:0];
	endfunction

	function automatic int idle_phase();
		return (numbers_taken * 3) / total_numbers;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > cycle_limit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// driver: predict each accepted number, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		int n_terms;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				n_terms = factorize(s_axis_tdata[31:0]);
				for (int i = 0; i < n_terms; i++)
					expected_terms.push_back(run_terms[i]);
				numbers_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (numbers_to_send.size() > 0 &&
				    $urandom_range(0, 99) >= (idle_phase() == 0 ? 26 :
				                              idle_phase() == 1 ? 80 : 0)) begin
					s_axis_tdata <= numbers_to_send.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transfer with the oldest expected term
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_term.factor = m_axis_tdata[tdf_pkg::FACTOR_W-1:0];
				got_term.exponent = m_axis_tdata[tdf_pkg::FACTOR_W +: tdf_pkg::EXP_W];
				got_term.last = m_axis_tlast;
				if (expected_terms.size() == 0) begin
					$error("unexpected result: factor %0d exponent %0d last %0b",
					       got_term.factor, got_term.exponent, got_term.last);
					error_count++;
				end else begin
					if (got_term.factor !== expected_terms[0].factor) begin
						$error("factor: expected %0d, got %0d",
						       expected_terms[0].factor, got_term.factor);
						error_count++;
					end
					if (got_term.exponent !== expected_terms[0].exponent) begin
						$error("exponent: expected %0d, got %0d",
						       expected_terms[0].exponent, got_term.exponent);
						error_count++;
					end
					if (got_term.last !== expected_terms[0].last) begin
						$error("last: expected %0b, got %0b",
						       expected_terms[0].last, got_term.last);
						error_count++;
					end
					void'(expected_terms.pop_front());
				end
				terms_seen++;
				if (got_term.exponent > top_exponent)
					top_exponent = got_term.exponent;
			end
			m_axis_tready <= $urandom_range(0, 99) >= (idle_phase() == 0 ? 80 :
			                                            idle_phase() == 1 ? 26 : 0);
		end
	end

	initial begin
		longint     budget;
		logic [31:0] num;
		int         n;
		int         pick;
		numbers_to_send = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12,
		                    32'h8000_0000, 32'hFFFF_FFFF, 32'd223092870,
		                    32'd3486784401, 32'd63001, 32'd65521, 32'd2000006,
		                    32'd4294836225, 32'd1045504, 32'd30030, 32'd1073741826};
		repeat (RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				num = smooth_number();
			else if (pick < 80)
				num = $urandom_range(0, 65535);
			else if (pick < 88)
				num = $urandom_range(65536, 1 << 20);
			else if (pick < 94)
				num = 32'd1 << $urandom_range(0, 31);
			else
				num = $urandom_range(0, 1);
			numbers_to_send.push_back(num);
		end
		total_numbers = numbers_to_send.size();
		budget = 0;
		foreach (numbers_to_send[i]) begin
			n = factorize(numbers_to_send[i]);
			if (n > longest_run)
				longest_run = n;
			budget += 40 * (trial_work + 2) + 100 * n + 100;
		end
		cycle_limit = 4 * budget + 50000;

		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (numbers_to_send.size() > 0 || s_axis_tvalid || expected_terms.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (expected_terms.size() != 0) begin
			$error("%0d expected terms never arrived", expected_terms.size());
			error_count++;
		end

		$display("factored %0d numbers into %0d prime terms in %0d cycles",
		         numbers_taken, terms_seen, cycle_count);
		$display("longest run %0d terms, highest exponent %0d, %0d errors",
		         longest_run, top_exponent, error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### sim.f
design/tdf_pkg.sv
design/tdf_divider.sv
design/tdf_datapath.sv
design/tdf_ctrl.sv
design/trial_division_factorizer.sv
design/tdf_checker.sv
bench/trial_division_factorizer_tb.sv
